>>> hdl/ksth_pkg.sv
// Package for the keyed triple SHA-1 digest pipeline.
// Holds the SHA-1 constants, the fixed key and the round/schedule functions.
// Used by every module of the block; depends on nothing.
package ksth_pkg;

  localparam int unsigned Rounds = 80;

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  localparam logic [127:0] KeyBytes = 128'h77214d4b_196a87cd_520045fd_20a51d67;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_state_t;

  typedef logic [511:0] sha_block_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic sha_state_t sha_round(input sha_state_t s, input logic [31:0] w,
                                           input int unsigned idx);
    logic [31:0] f;
    logic [31:0] k;
    sha_state_t r;
    if (idx < 20) begin
      f = (s.b & s.c) | (~s.b & s.d);
      k = 32'h5A827999;
    end else if (idx < 40) begin
      f = s.b ^ s.c ^ s.d;
      k = 32'h6ED9EBA1;
    end else if (idx < 60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = s.b ^ s.c ^ s.d;
      k = 32'hCA62C1D6;
    end
    r.a = rotl(s.a, 5) + f + s.e + k + w;
    r.b = s.a;
    r.c = rotl(s.b, 30);
    r.d = s.c;
    r.e = s.d;
    sha_round = r;
  endfunction

  // Shift the 16-word window one word ahead.
  function automatic sha_block_t sched_next(input sha_block_t w);
    logic [31:0] nw;
    nw = rotl(w[95:64] ^ w[255:224] ^ w[447:416] ^ w[511:480], 1);
    sched_next = {w[479:0], nw};
  endfunction

  function automatic logic [159:0] sha_final(input sha_state_t s);
    sha_final = {s.a + ShaInit[159:128], s.b + ShaInit[127:96], s.c + ShaInit[95:64],
                 s.d + ShaInit[63:32], s.e + ShaInit[31:0]};
  endfunction

endpackage

>>> hdl/ksth_sha1_pipe.sv
// Fully pipelined single-block SHA-1: one round per register stage.
// Carries a side payload along with each block. Depends on ksth_pkg.
module ksth_sha1_pipe #(
  parameter int unsigned SideW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  ksth_pkg::sha_block_t  block_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic [159:0]          digest_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned N = ksth_pkg::Rounds;

  logic                 vld_q  [N];
  ksth_pkg::sha_state_t st_q   [N];
  ksth_pkg::sha_block_t win_q  [N];
  logic [SideW-1:0]     side_q [N];

  for (genvar g = 0; g < N; g++) begin : g_round
    ksth_pkg::sha_state_t st_in;
    ksth_pkg::sha_block_t win_in;
    logic [SideW-1:0]     side_in;
    logic                 vld_in;
    if (g == 0) begin : g_first
      assign st_in   = ksth_pkg::ShaInit;
      assign win_in  = block_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_rest
      assign st_in   = st_q[g-1];
      assign win_in  = ksth_pkg::sched_next(win_q[g-1]);
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g]   <= ksth_pkg::sha_round(st_in, win_in[511:480], g);
        win_q[g]  <= win_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o  = vld_q[N-1];
  assign digest_o = ksth_pkg::sha_final(st_q[N-1]);
  assign side_o   = side_q[N-1];

endmodule

>>> hdl/keyed_sha1_triple_hash.sv
// Top level of the keyed triple SHA-1 digest.
// Chains three ksth_sha1_pipe instances; depends on ksth_pkg.
//
// Usage: present a plaintext item on plaintext_i with valid_i; it is taken
// when valid_i and ready_o are both high. One digest item leaves on
// digest_hi_o/digest_mid_o/digest_lo_o with valid_o, taken when ready_i is high.
// Throughput: one item per cycle when not stalled. Each item passes through
// three 80-round SHA-1 pipelines (one round per stage) and the output register.
// The whole pipeline advances as one unit: when the output register holds an
// item that is not taken, every stage holds, empty slots included, and ready_o
// falls. Reset clears all valid bits; payload registers are not reset.
// Nothing is kept between items.
module keyed_sha1_triple_hash #(
  parameter int unsigned PLAINTEXT_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] plaintext_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] digest_hi_o,
  output logic [63:0] digest_mid_o,
  output logic [31:0] digest_lo_o
);

  localparam int unsigned PB = PLAINTEXT_BYTES;
  localparam int unsigned PW = 8 * PB;
  localparam int unsigned L1 = 16 + PB;
  localparam int unsigned L2 = 36 + PB;

  logic [PW-1:0] ptxt;
  logic          en;
  logic          out_vld_q;
  logic [159:0]  out_q;

  if (PB >= 4) begin : g_wide
    assign ptxt = PW'(plaintext_i);
  end else begin : g_narrow
    assign ptxt = plaintext_i[PW-1:0];
  end

  assign en      = !out_vld_q || ready_i;
  assign ready_o = en;

  ksth_pkg::sha_block_t blk1, blk2, blk3;
  logic          v1, v2, v3;
  logic [159:0]  d1, d2, d3;
  logic [PW-1:0] s1;
  logic [127:0]  s2;
  logic          unused_s3;

  assign blk1 = {ksth_pkg::KeyBytes, ptxt, 8'h80, {(512-128-PW-8-64){1'b0}},
                 64'(L1 * 8)};

  ksth_sha1_pipe #(.SideW(PW)) u_h1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i && en), .block_i(blk1),
    .side_i(ptxt), .valid_o(v1), .digest_o(d1), .side_o(s1)
  );

  assign blk2 = {ksth_pkg::KeyBytes, d1, s1, 8'h80, {(512-288-PW-8-64){1'b0}},
                 64'(L2 * 8)};

  ksth_sha1_pipe #(.SideW(128)) u_h2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .block_i(blk2),
    .side_i(d1[159:32]), .valid_o(v2), .digest_o(d2), .side_o(s2)
  );

  assign blk3 = {s2, d2[159:32], 8'h80, {(256-8-16){1'b0}}, 16'd256};

  ksth_sha1_pipe #(.SideW(1)) u_h3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .block_i(blk3),
    .side_i(1'b0), .valid_o(v3), .digest_o(d3),
    .side_o(unused_s3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= d3;
    end
  end

  assign valid_o      = out_vld_q;
  assign digest_hi_o  = out_q[159:96];
  assign digest_mid_o = out_q[95:32];
  assign digest_lo_o  = out_q[31:0];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(out_q))
    else $error("output item changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o == (!valid_o || ready_i))
    else $error("ready does not follow output register");
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !v3 |=> !valid_o)
    else $error("output item invented");

endmodule

>>> tb/testbench.sv
// Testbench for keyed_sha1_triple_hash: drives plaintext items, predicts the
// keyed triple SHA-1 digest of each and checks every digest item in order.
// Depends on ksth_pkg only for the key constant.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PtBytes = 4;
  localparam int unsigned RandItems = 1950;
  localparam int unsigned Latency = 241;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] mid;
    logic [31:0] lo;
  } digest_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [31:0] plaintext_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [63:0] digest_hi_o;
  logic [63:0] digest_mid_o;
  logic [31:0] digest_lo_o;

  logic [31:0] pending_pt[$];
  digest_t     expected_digests[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  bit          start_hold = 1'b0;
  bit          hold_active = 1'b0;

  keyed_sha1_triple_hash #(.PLAINTEXT_BYTES(PtBytes)) uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Single-block SHA-1 of the first len bytes of msg (byte 0 in msg[0]).
  function automatic logic [159:0] sha1_block(logic [7:0] msg[64], int len);
    logic [7:0]  blk[64];
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    logic [63:0] nbits;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
    blk[len] = 8'h80;
    nbits = 64'(len * 8);
    for (int i = 0; i < 8; i++) blk[63 - i] = nbits[8*i +: 8];
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE; d = 32'h10325476;
    e = 32'hC3D2E1F0;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
            d + 32'h10325476, e + 32'hC3D2E1F0};
  endfunction

  function automatic digest_t keyed_digest(logic [31:0] pt);
    logic [7:0]   msg[64];
    logic [7:0]   p[8];
    logic [63:0]  v;
    logic [159:0] kd, vd, dd;
    digest_t      r;
    v = {32'h0, pt};
    for (int i = 0; i < PtBytes; i++) p[i] = v[8*(PtBytes-1-i) +: 8];
    for (int i = 0; i < 64; i++) msg[i] = 8'h00;
    for (int i = 0; i < 16; i++) msg[i] = ksth_pkg::KeyBytes[127 - 8*i -: 8];
    for (int i = 0; i < PtBytes; i++) msg[16 + i] = p[i];
    kd = sha1_block(msg, 16 + PtBytes);
    for (int i = 0; i < 20; i++) msg[16 + i] = kd[159 - 8*i -: 8];
    for (int i = 0; i < PtBytes; i++) msg[36 + i] = p[i];
    vd = sha1_block(msg, 36 + PtBytes);
    for (int i = 0; i < 16; i++) begin
      msg[i] = kd[159 - 8*i -: 8];
      msg[16 + i] = vd[159 - 8*i -: 8];
    end
    dd = sha1_block(msg, 32);
    r.hi = dd[159:96];
    r.mid = dd[95:32];
    r.lo = dd[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: hold the item until accepted, then advance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        expected_digests.push_back(keyed_digest(plaintext_i));
      end
      if (!valid_i || ready_o) begin
        if (pending_pt.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          valid_i <= 1'b1;
          plaintext_i <= pending_pt.pop_front();
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each digest item against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("unexpected item", digest_hi_o, 64'h0);
        end else begin
          digest_t want;
          want = expected_digests.pop_front();
          if (digest_hi_o !== want.hi) report_mismatch("digest_hi", digest_hi_o, want.hi);
          if (digest_mid_o !== want.mid) report_mismatch("digest_mid", digest_mid_o, want.mid);
          if (digest_lo_o !== want.lo)
            report_mismatch("digest_lo", {32'h0, digest_lo_o}, {32'h0, want.lo});
        end
      end
      if (hold_active) begin
        ready_i <= 1'b0;
      end else begin
        ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  initial begin
    wait (start_hold);
    hold_active = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active = 1'b0;
  end

  task automatic drain();
    while (pending_pt.size() > 0 || valid_i) @(posedge clk_i);
    while (expected_digests.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pct_send[4] = '{0, 54, 0, 21};
    int unsigned pct_recv[4] = '{0, 0, 54, 21};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_pt.push_back(32'h0000_0000);
    pending_pt.push_back(32'hFFFF_FFFF);
    pending_pt.push_back(32'h8000_0000);
    pending_pt.push_back(32'h0000_0001);
    pending_pt.push_back(32'h5555_5555);
    pending_pt.push_back(32'hAAAA_AAAA);
    pending_pt.push_back(32'h7FFF_FFFF);
    pending_pt.push_back(32'hFF00_00FF);
    for (int i = 0; i < 32; i++) pending_pt.push_back(32'h1 << i);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < RandItems / 4; i++) pending_pt.push_back($urandom);
      if (ph == 0) start_hold = 1'b1;
      drain();
    end
    repeat (Latency + 20) @(posedge clk_i);
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> keyed_sha1_triple_hash.f
hdl/ksth_pkg.sv
hdl/ksth_sha1_pipe.sv
hdl/keyed_sha1_triple_hash.sv
tb/testbench.sv
